[sv/gscs_pkg.sv]
// shared types, constants and the force scaling function of the gap spring channel
`timescale 1ns / 1ps
`default_nettype none

package gscs_pkg;

  localparam int FRAC_BITS = 16;

  localparam int DISP_W  = 32;
  localparam int DEF_W   = DISP_W + 1;   // disp_j - disp_i
  localparam int LEN_W   = DEF_W + 1;    // deformation plus or minus the gap
  localparam int CMP_W   = LEN_W + 1;    // threshold compares
  localparam int PROD_W  = DISP_W + LEN_W;
  localparam int FORCE_W = 48;

  localparam int IN_DATA_W  = 64;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 136;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SPRING_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_SIZE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_TOLERANCE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_BAND      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_USE_HYSTERESIS = 3'd5;

  // spring behavior codes
  localparam logic [1:0] MODE_LINEAR      = 2'd0;
  localparam logic [1:0] MODE_TENSION     = 2'd1;
  localparam logic [1:0] MODE_COMPRESSION = 2'd2;

  localparam logic signed [PROD_W-1:0] FORCE_MAX =
    PROD_W'((66'sd1 <<< (FORCE_W - 1)) - 66'sd1);
  localparam logic signed [PROD_W-1:0] FORCE_MIN =
    PROD_W'(-(66'sd1 <<< (FORCE_W - 1)));

  typedef struct packed {
    logic [1:0]         spring_mode;
    logic signed [31:0] gap_size;
    logic signed [31:0] stiffness;
    logic [30:0]        gap_tolerance;
    logic [30:0]        hyst_band;
    logic               use_hysteresis;
  } gscs_cfg_t;

  typedef struct packed {
    logic signed [DISP_W-1:0] disp_i;
    logic signed [DISP_W-1:0] disp_j;
    logic                     end_i_fixed;
    logic                     end_j_fixed;
  } gscs_in_t;

  // operands for the force multipliers
  typedef struct packed {
    logic signed [DEF_W-1:0] deformation;
    logic                    active;
    logic                    changed;
    logic signed [LEN_W-1:0] sf_len;
    logic signed [LEN_W-1:0] gf_len;
  } gscs_op_t;

  typedef struct packed {
    logic signed [DEF_W-1:0]  deformation;
    logic                     active;
    logic                     changed;
    logic signed [PROD_W-1:0] sf_prod;
    logic signed [PROD_W-1:0] gf_prod;
  } gscs_prod_t;

  // floor of the product over 2^FRAC_BITS, clamped to the signed force range
  function automatic logic signed [FORCE_W-1:0] force_scale(
    input logic signed [PROD_W-1:0] prod
  );
    logic signed [PROD_W-1:0] shifted;
    logic signed [FORCE_W-1:0] res;
    shifted = prod >>> FRAC_BITS;
    if (shifted > FORCE_MAX) begin
      res = FORCE_MAX[FORCE_W-1:0];
    end else if (shifted < FORCE_MIN) begin
      res = FORCE_MIN[FORCE_W-1:0];
    end else begin
      res = shifted[FORCE_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/gap_spring_contact_state_top.sv]
// top level of one gap spring channel: config registers, engage flag and force pipeline
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake             | payload
// in_      | slave     | in_tvalid / in_tready | tdata: disp_i, disp_j; tuser: fixed-end flags
// out_     | master    | out_tvalid/out_tready | tdata: deformation, flags, two forces
// cfg_     | slave     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one transaction per cycle sustained while out_tready stays high; each item passes the stages below in order
// stages: input register, decision and operand register, product register, output
// each stage has its own valid bit, so bubbles close up and an item is taken while
// a finished result still waits on out_tready
// engage flag resets to one and follows each item as it leaves the decision stage
// rst_n is synchronous, active low; config registers reset to zero

module gap_spring_contact_state_top
  import gscs_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,

  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire [IN_DATA_W-1:0]   in_tdata,   // disp_i[31:0], disp_j[63:32]
  input  wire [IN_USER_W-1:0]   in_tuser,   // end_i_fixed[0], end_j_fixed[1]

  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // deformation[32:0], active[33], changed[34],
                                            // spring_force[82:35], gap_force[130:83], zeros

  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [CFG_IDX_W-1:0]   cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_data
);

  gscs_cfg_t  cfg_r;
  logic       engaged_r;

  logic       s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  gscs_in_t   s1_r;
  gscs_op_t   s2_r;
  gscs_prod_t s3_r;
  logic signed [DEF_W-1:0]   s4_def_r;
  logic                      s4_act_r;
  logic                      s4_chg_r;
  logic signed [FORCE_W-1:0] s4_sf_r;
  logic signed [FORCE_W-1:0] s4_gf_r;

  logic       rdy1, rdy2, rdy3, rdy4;
  gscs_op_t   dec_op;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SPRING_MODE:    cfg_r.spring_mode    <= cfg_data[1:0];
        REG_GAP_SIZE:       cfg_r.gap_size       <= $signed(cfg_data);
        REG_STIFFNESS:      cfg_r.stiffness      <= $signed(cfg_data);
        REG_GAP_TOLERANCE:  cfg_r.gap_tolerance  <= cfg_data[30:0];
        REG_HYST_BAND:      cfg_r.hyst_band      <= cfg_data[30:0];
        REG_USE_HYSTERESIS: cfg_r.use_hysteresis <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // per-stage ready chain
  assign rdy4      = !s4_v_r || out_tready;
  assign rdy3      = !s3_v_r || rdy4;
  assign rdy2      = !s2_v_r || rdy3;
  assign rdy1      = !s1_v_r || rdy2;
  assign in_tready = rdy1;

  gscs_decide u_decide (
    .item        (s1_r),
    .cfg         (cfg_r),
    .prev_active (engaged_r),
    .op          (dec_op)
  );

  // valid bits and the engage flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      s4_v_r    <= 1'b0;
      engaged_r <= 1'b1;
    end else begin
      if (rdy1) s1_v_r <= in_tvalid;
      if (rdy2) s2_v_r <= s1_v_r;
      if (rdy3) s3_v_r <= s2_v_r;
      if (rdy4) s4_v_r <= s3_v_r;
      // flag moves with the item leaving the decision stage
      if (rdy2 && s1_v_r) engaged_r <= dec_op.active;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      s1_r.disp_i      <= $signed(in_tdata[31:0]);
      s1_r.disp_j      <= $signed(in_tdata[63:32]);
      s1_r.end_i_fixed <= in_tuser[0];
      s1_r.end_j_fixed <= in_tuser[1];
    end
    if (rdy2 && s1_v_r) begin
      s2_r <= dec_op;
    end
    if (rdy3 && s2_v_r) begin
      s3_r.deformation <= s2_r.deformation;
      s3_r.active      <= s2_r.active;
      s3_r.changed     <= s2_r.changed;
      s3_r.sf_prod     <= PROD_W'(cfg_r.stiffness) * PROD_W'(s2_r.sf_len);
      s3_r.gf_prod     <= PROD_W'(cfg_r.stiffness) * PROD_W'(s2_r.gf_len);
    end
    if (rdy4 && s3_v_r) begin
      s4_def_r <= s3_r.deformation;
      s4_act_r <= s3_r.active;
      s4_chg_r <= s3_r.changed;
      s4_sf_r  <= force_scale(s3_r.sf_prod);
      s4_gf_r  <= force_scale(s3_r.gf_prod);
    end
  end

  assign out_tvalid = s4_v_r;
  assign out_tdata  = {5'd0, s4_gf_r, s4_sf_r, s4_chg_r, s4_act_r, s4_def_r};

  // flag register takes the decision of the item that left stage one
  a_flag_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy2 && s1_v_r) |=> (engaged_r == s2_r.active))
    else $error("engage flag does not match the last decision");

  // an inactive spring carries no force into the product stage
  a_idle_no_prod: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_v_r && !s3_r.active) |-> (s3_r.sf_prod == '0 && s3_r.gf_prod == '0))
    else $error("inactive spring produced a force");

  // changed flag in flight is consistent with the flag register before the update
  a_changed: assert property (@(posedge clk) disable iff (!rst_n)
    (rdy2 && s1_v_r) |=> (s2_r.changed == (s2_r.active ^ $past(engaged_r))))
    else $error("changed flag inconsistent with previous engage state");

  // an inactive result shows zero forces at the output
  a_out_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s4_v_r && !s4_act_r) |-> (s4_sf_r == '0 && s4_gf_r == '0))
    else $error("inactive result carries nonzero force");

endmodule

`default_nettype wire

[sv/gscs_decide.sv]
// engagement decision and multiplier operand selection for one channel
`timescale 1ns / 1ps
`default_nettype none

module gscs_decide
  import gscs_pkg::*;
(
  input  wire gscs_in_t  item,
  input  wire gscs_cfg_t cfg,
  input  wire            prev_active,
  output gscs_op_t       op
);

  logic signed [DEF_W-1:0] ui;
  logic signed [DEF_W-1:0] uj;
  logic signed [DEF_W-1:0] d;
  logic signed [CMP_W-1:0] dw;
  logic signed [CMP_W-1:0] adw;
  logic signed [CMP_W-1:0] gw;
  logic signed [CMP_W-1:0] hw;
  logic signed [CMP_W-1:0] tw;
  logic signed [CMP_W-1:0] thr;
  logic signed [LEN_W-1:0] d_l;
  logic signed [LEN_W-1:0] g_l;
  logic [1:0]              mode;
  logic                    no_gap;
  logic                    d_gt_g;
  logic                    d_lt_ng;
  logic                    act;

  always_comb begin
    ui = item.end_i_fixed ? '0 : DEF_W'(item.disp_i);
    uj = item.end_j_fixed ? '0 : DEF_W'(item.disp_j);
    d  = uj - ui;

    dw  = CMP_W'(d);
    adw = d[DEF_W-1] ? -dw : dw;
    gw  = CMP_W'(cfg.gap_size);
    hw  = cfg.use_hysteresis ? $signed(CMP_W'(cfg.hyst_band)) : '0;
    tw  = $signed(CMP_W'(cfg.gap_tolerance));

    // unused mode code behaves as linear
    mode = (cfg.spring_mode == MODE_TENSION || cfg.spring_mode == MODE_COMPRESSION) ?
           cfg.spring_mode : MODE_LINEAR;

    no_gap  = (gw <= tw);
    d_gt_g  = (dw > gw);
    d_lt_ng = (dw < -gw);

    unique case (mode)
      MODE_TENSION: begin
        thr = prev_active ? (gw - hw - tw) : (gw + hw - tw);
        act = (dw > thr);
      end
      MODE_COMPRESSION: begin
        thr = prev_active ? (hw + tw - gw) : (tw - gw - hw);
        act = (dw < thr);
      end
      default: begin
        thr = prev_active ? (gw - hw - tw) : (gw + hw - tw);
        act = no_gap || (adw > thr);
      end
    endcase

    d_l = LEN_W'(d);
    g_l = LEN_W'(cfg.gap_size);

    op.deformation = d;
    op.active      = act;
    op.changed     = act ^ prev_active;
    op.sf_len      = '0;
    op.gf_len      = '0;

    if (act) begin
      unique case (mode)
        MODE_TENSION:     op.sf_len = d_l - g_l;
        MODE_COMPRESSION: op.sf_len = d_l + g_l;
        default: begin
          priority if (no_gap) begin
            op.sf_len = d_l;
          end else if (d_gt_g) begin
            op.sf_len = d_l - g_l;
          end else if (d_lt_ng) begin
            op.sf_len = d_l + g_l;
          end else begin
            // engaged but still inside the gap
            op.sf_len = '0;
          end
        end
      endcase
      if (!no_gap) begin
        unique case (mode)
          MODE_TENSION:     op.gf_len = -g_l;
          MODE_COMPRESSION: op.gf_len = g_l;
          default: begin
            priority if (d_gt_g) begin
              op.gf_len = -g_l;
            end else if (d_lt_ng) begin
              op.gf_len = g_l;
            end else begin
              op.gf_len = '0;
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[dv/gap_spring_contact_state_top_tb.sv]
// self-checking testbench of one gap spring channel: directed table, random phases, scoreboard
`timescale 1ns / 1ps

module gap_spring_contact_state_top_tb;
  import gscs_pkg::*;

  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off for back-pressure
  localparam int STALL_LIMIT    = 2000;  // cycles without any transaction before giving up
  localparam int SETTLE_CYCLES  = 8;     // pipeline is four deep, leave some margin
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 150;
  localparam int PRESSURE_PHASE = 4;
  localparam int MAX_REPORTS    = 10;

  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_USE_HYSTERESIS + 3'd1;

  // one result transaction, kept as raw bit fields for comparison
  typedef struct {
    logic [DEF_W-1:0]   deformation;
    logic               active;
    logic               changed;
    logic [FORCE_W-1:0] spring_force;
    logic [FORCE_W-1:0] gap_force;
  } contact_result_t;

  // one row of the directed table: a register write or an input item
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
    gscs_in_t              item;
    bit                    typed;   // result written out by hand in the row
    contact_result_t       result;
  } stim_row_t;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor copy of the registers and of the engage flag
  gscs_cfg_t       spring_cfg;
  logic            engaged;
  contact_result_t contact_q[$];   // expected results, oldest first
  stim_row_t       directed_rows[$];

  bit              typed_next;     // item on the bus carries a hand-written result
  contact_result_t typed_result;
  bit              tx_idle;        // sender inserts random gaps
  bit              rx_idle;        // receiver inserts random stalls
  bit              hold_pending;   // receiver should do one long hold-off
  int              mismatches   = 0;
  int              quiet_cycles = 0;

  gap_spring_contact_state_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // floor(k * len / 2^FRAC_BITS), clamped to the signed force range
  function automatic logic [FORCE_W-1:0] scale_force(longint k, longint len);
    logic signed [95:0] a;
    logic signed [95:0] b;
    logic signed [95:0] prod;
    logic signed [95:0] top;
    logic signed [95:0] bottom;
    a      = 96'(k);
    b      = 96'(len);
    prod   = (a * b) >>> FRAC_BITS;
    top    = (96'sd1 <<< (FORCE_W - 1)) - 96'sd1;
    bottom = -(96'sd1 <<< (FORCE_W - 1));
    if (prod > top) prod = top;
    else if (prod < bottom) prod = bottom;
    return prod[FORCE_W-1:0];
  endfunction

  function automatic void apply_write(logic [CFG_IDX_W-1:0] idx,
                                      logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_SPRING_MODE:    spring_cfg.spring_mode    = value[1:0];
      REG_GAP_SIZE:       spring_cfg.gap_size       = value;
      REG_STIFFNESS:      spring_cfg.stiffness      = value;
      REG_GAP_TOLERANCE:  spring_cfg.gap_tolerance  = value[30:0];
      REG_HYST_BAND:      spring_cfg.hyst_band      = value[30:0];
      REG_USE_HYSTERESIS: spring_cfg.use_hysteresis = value[0];
      default: ;
    endcase
  endfunction

  // engage decision and forces for one item; advances the engage flag
  function automatic contact_result_t predict_contact(gscs_in_t it);
    longint          ui, uj, d, ad, g, k, tol, h;
    logic [1:0]      mode;
    logic            prev, act;
    logic            gap_open;
    contact_result_t r;
    ui   = 0;
    uj   = 0;
    if (!it.end_i_fixed) ui = longint'(it.disp_i);
    if (!it.end_j_fixed) uj = longint'(it.disp_j);
    d    = uj - ui;
    ad   = (d < 0) ? -d : d;
    g    = longint'(spring_cfg.gap_size);
    k    = longint'(spring_cfg.stiffness);
    tol  = longint'({1'b0, spring_cfg.gap_tolerance});
    h    = spring_cfg.use_hysteresis ? longint'({1'b0, spring_cfg.hyst_band}) : 0;
    mode = spring_cfg.spring_mode;
    // the unused mode code falls back to linear
    if (mode != MODE_TENSION && mode != MODE_COMPRESSION) mode = MODE_LINEAR;
    prev     = engaged;
    gap_open = (g > tol);

    // thresholds move apart by the band once hysteresis is on
    if (mode == MODE_TENSION) act = prev ? (d > g - h - tol) : (d > g + h - tol);
    else if (mode == MODE_COMPRESSION) act = prev ? (d < -g + h + tol) : (d < -g - h + tol);
    else if (!gap_open) act = 1'b1;
    else act = prev ? (ad > g - h - tol) : (ad > g + h - tol);
    engaged = act;

    r.deformation  = d[DEF_W-1:0];
    r.active       = act;
    r.changed      = (act != prev);
    r.spring_force = '0;
    r.gap_force    = '0;
    if (act) begin
      if (mode == MODE_TENSION) r.spring_force = scale_force(k, d - g);
      else if (mode == MODE_COMPRESSION) r.spring_force = scale_force(k, d + g);
      else if (!gap_open) r.spring_force = scale_force(k, d);
      else if (d > g) r.spring_force = scale_force(k, d - g);
      else if (d < -g) r.spring_force = scale_force(k, d + g);
      // closure force only where a real gap exists
      if (gap_open) begin
        if (mode == MODE_TENSION) r.gap_force = scale_force(k, -g);
        else if (mode == MODE_COMPRESSION) r.gap_force = scale_force(k, g);
        else if (d > g) r.gap_force = scale_force(k, -g);
        else if (d < -g) r.gap_force = scale_force(k, g);
      end
    end
    return r;
  endfunction

  // register writes and accepted inputs feed the predictor
  always @(posedge clk) begin
    contact_result_t r;
    if (!rst_n) begin
      spring_cfg = '0;
      engaged    = 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_tvalid && in_tready) begin
        r = predict_contact('{disp_i: in_tdata[31:0], disp_j: in_tdata[63:32],
                               end_i_fixed: in_tuser[0], end_j_fixed: in_tuser[1]});
        // hand-written rows override the predictor, which still tracks the flag
        if (typed_next) r = typed_result;
        contact_q.push_back(r);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // scoreboard
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch %s: expected %h, got %h", name, want, got);
    end
  endfunction

  // out_tdata: deformation[32:0], active[33], changed[34], spring_force[82:35],
  // gap_force[130:83]
  always @(posedge clk) begin
    contact_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (contact_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result transaction with nothing expected: %h", out_tdata);
      end else begin
        want = contact_q.pop_front();
        check_field("deformation", 64'(want.deformation), 64'(out_tdata[32:0]));
        check_field("active", 64'(want.active), 64'(out_tdata[33]));
        check_field("changed", 64'(want.changed), 64'(out_tdata[34]));
        check_field("spring_force", 64'(want.spring_force), 64'(out_tdata[82:35]));
        check_field("gap_force", 64'(want.gap_force), 64'(out_tdata[130:83]));
      end
    end
  end

  // watchdog: any accepted transaction on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("FAIL gap_spring_contact_state_top");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // bus drivers, all changes on the falling edge
  // ---------------------------------------------------------------------------

  task automatic send_item(gscs_in_t it, bit typed, contact_result_t res);
    int gap;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata     = {it.disp_j, it.disp_i};
    in_tuser     = {it.end_j_fixed, it.end_i_fixed};
    typed_next   = typed;
    typed_result = res;
    in_tvalid    = 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // stop offering items, wait for every result, then let the pipeline empty
  task automatic drain_and_settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (contact_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: a random stall before each result, one long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_pending) begin
        @(negedge clk);
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_pending = 1'b0;
      end else begin
        stall = rx_idle ? $urandom_range(0, 5) : 0;
        if (stall > 0) begin
          @(negedge clk);
          out_tready = 1'b0;
          repeat (stall - 1) @(negedge clk);
        end
      end
      @(negedge clk);
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row.is_write  = 1'b1;
    row.reg_index = idx;
    row.reg_value = value;
    row.item      = '0;
    row.typed     = 1'b0;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(logic [31:0] di, logic [31:0] dj, logic fi, logic fj,
                                      bit typed, logic [DEF_W-1:0] def, logic act,
                                      logic chg, logic [FORCE_W-1:0] sf,
                                      logic [FORCE_W-1:0] gf);
    stim_row_t row;
    row.is_write            = 1'b0;
    row.reg_index           = '0;
    row.reg_value           = '0;
    row.item                = '{disp_i: di, disp_j: dj, end_i_fixed: fi, end_j_fixed: fj};
    row.typed               = typed;
    row.result.deformation  = def;
    row.result.active       = act;
    row.result.changed      = chg;
    row.result.spring_force = sf;
    row.result.gap_force    = gf;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_item(logic [31:0] di, logic [31:0] dj, logic fi, logic fj);
    add_checked(di, dj, fi, fj, 1'b0, '0, 1'b0, 1'b0, '0, '0);
  endfunction

  function automatic void build_table();
    // after reset: linear, zero gap and stiffness, so engaged with no force
    add_checked(32'h0, 32'h0, 1'b0, 1'b0, 1'b1, 33'h0, 1'b1, 1'b0, '0, '0);
    add_checked(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 33'h0_FFFF_FFFF,
                1'b1, 1'b0, '0, '0);
    add_checked(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b1, 33'h1_0000_0001,
                1'b1, 1'b0, '0, '0);
    // constrained ends count as zero
    add_checked(32'd5, 32'd7, 1'b1, 1'b0, 1'b1, 33'd7, 1'b1, 1'b0, '0, '0);
    add_checked(32'd5, 32'd7, 1'b0, 1'b1, 1'b1, 33'h1_FFFF_FFFB, 1'b1, 1'b0, '0, '0);
    add_checked(32'd5, 32'd7, 1'b1, 1'b1, 1'b1, 33'h0, 1'b1, 1'b0, '0, '0);
    // tension with the most negative gap: force clamps at both ends
    add_write(REG_SPRING_MODE, {30'd0, MODE_TENSION});
    add_write(REG_GAP_SIZE, 32'h8000_0000);
    add_write(REG_STIFFNESS, 32'h7FFF_FFFF);
    add_checked(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 33'h0_FFFF_FFFF, 1'b1, 1'b0,
                48'h7FFF_FFFF_FFFF, '0);
    add_write(REG_STIFFNESS, 32'h8000_0000);
    add_checked(32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 33'h0_FFFF_FFFF, 1'b1, 1'b0,
                48'h8000_0000_0000, '0);
    // pulled far into compression: disengages, forces drop to zero
    add_checked(32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b1, 33'h1_0000_0001,
                1'b0, 1'b1, '0, '0);
    // linear with a 3.0 gap, 0.5 tolerance, stiffness 2.0
    add_write(REG_SPRING_MODE, {30'd0, MODE_LINEAR});
    add_write(REG_GAP_SIZE, 32'h0003_0000);
    add_write(REG_STIFFNESS, 32'h0002_0000);
    add_write(REG_GAP_TOLERANCE, 32'h0000_8000);
    add_item(32'h0, 32'h0001_0000, 1'b0, 1'b0);   // inside the gap, stays off
    add_item(32'h0, 32'h0004_0000, 1'b0, 1'b0);   // past the gap on the tension side
    add_item(32'h0, 32'h0002_CCCC, 1'b0, 1'b0);   // engaged but inside the gap
    add_item(32'h0004_0000, 32'h0, 1'b0, 1'b0);   // past the gap on the compression side
    // hysteresis band of 1.0
    add_write(REG_HYST_BAND, 32'h0001_0000);
    add_write(REG_USE_HYSTERESIS, 32'd1);
    add_item(32'h0, 32'h0, 1'b0, 1'b0);           // releases
    add_item(32'h0, 32'h0003_8000, 1'b0, 1'b0);   // sits on the upper threshold, stays off
    add_item(32'h0, 32'h0004_8000, 1'b0, 1'b0);   // engages
    add_item(32'h0, 32'h0002_0000, 1'b0, 1'b0);   // held on by the band
    // unused mode code acts as linear
    add_write(REG_SPRING_MODE, 32'd3);
    add_item(32'h0001_0000, 32'h0006_0000, 1'b0, 1'b0);
    // compression only with a 1.0 gap and no tolerance
    add_write(REG_SPRING_MODE, {30'd0, MODE_COMPRESSION});
    add_write(REG_GAP_SIZE, 32'h0001_0000);
    add_write(REG_GAP_TOLERANCE, 32'h0);
    add_item(32'h0003_0000, 32'h0, 1'b0, 1'b0);
    add_item(32'h0, 32'h0003_0000, 1'b0, 1'b0);
    // gap below the tolerance: no closure force in any mode
    add_write(REG_GAP_SIZE, 32'h0000_4000);
    add_write(REG_GAP_TOLERANCE, 32'h0000_8000);
    add_item(32'h0003_0000, 32'h0, 1'b0, 1'b0);
    add_write(REG_SPRING_MODE, {30'd0, MODE_LINEAR});
    add_item(32'h0001_2345, 32'hFFFF_0000, 1'b0, 1'b0);
    // negative gap in linear mode counts as no gap
    add_write(REG_GAP_SIZE, 32'hFFFF_0000);
    add_item(32'hFFF0_0000, 32'h000F_0000, 1'b0, 1'b0);
  endfunction

  function automatic logic [31:0] corner_value();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return 32'h1;
    endcase
  endfunction

  // mostly deformations right around the current engage thresholds
  function automatic gscs_in_t random_item();
    gscs_in_t it;
    longint   g, h, tol, base, sum;
    int       jit;
    g   = longint'(spring_cfg.gap_size);
    tol = longint'({1'b0, spring_cfg.gap_tolerance});
    h   = spring_cfg.use_hysteresis ? longint'({1'b0, spring_cfg.hyst_band}) : 0;
    it.end_i_fixed = ($urandom_range(0, 7) == 0);
    it.end_j_fixed = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 9))
      0: begin
        it.disp_i = $urandom;
        it.disp_j = $urandom;
      end
      1: begin
        it.disp_i = corner_value();
        it.disp_j = corner_value();
      end
      default: begin
        case ($urandom_range(0, 5))
          0: base = g;
          1: base = -g;
          2: base = g - h - tol;
          3: base = g + h - tol;
          4: base = -g + h + tol;
          default: base = -g - h + tol;
        endcase
        if ($urandom_range(0, 3) == 0) jit = $urandom_range(0, 1 << 17) - (1 << 16);
        else jit = $urandom_range(0, 8) - 4;
        if ($urandom_range(0, 3) == 0) it.disp_i = $urandom;
        else it.disp_i = $urandom_range(0, 1 << 20) - (1 << 19);
        sum       = longint'(it.disp_i) + base + jit;
        it.disp_j = sum[31:0];
      end
    endcase
    return it;
  endfunction

  // first two phases take the register extremes, the rest random settings
  task automatic random_config(int phase);
    logic [31:0] gap, stiff, tol, band, junk;
    logic [1:0]  mode;
    logic        hyst;
    junk = $urandom;
    if (phase == 0) begin
      mode  = MODE_TENSION;
      gap   = 32'h7FFF_FFFF;
      stiff = 32'h7FFF_FFFF;
      tol   = 32'h7FFF_FFFF;
      band  = 32'h7FFF_FFFF;
      hyst  = 1'b1;
    end else if (phase == 1) begin
      mode  = MODE_COMPRESSION;
      gap   = 32'h8000_0000;
      stiff = 32'h8000_0000;
      tol   = 32'h0;
      band  = 32'h0;
      hyst  = 1'b0;
    end else begin
      mode = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0: gap = $urandom_range(1, 1 << 20);
        1: gap = -$urandom_range(1, 1 << 20);
        2: gap = $urandom;
        3: gap = 32'h0;
        default: gap = $urandom_range(1 << 16, 1 << 24);
      endcase
      if ($urandom_range(0, 2) == 0) stiff = $urandom;
      else stiff = $urandom_range(0, 1 << 19) - (1 << 18);
      // a full word also sets the bit above the register
      case ($urandom_range(0, 4))
        0: tol = $urandom;
        1: tol = gap + $urandom_range(0, 1 << 12);
        default: tol = $urandom_range(0, 1 << 14);
      endcase
      if ($urandom_range(0, 4) == 0) band = $urandom;
      else band = $urandom_range(0, 1 << 16);
      hyst = 1'($urandom_range(0, 1));
    end
    write_reg(REG_SPRING_MODE, {junk[31:2], mode});
    write_reg(REG_GAP_SIZE, gap);
    write_reg(REG_STIFFNESS, stiff);
    write_reg(REG_GAP_TOLERANCE, tol);
    write_reg(REG_HYST_BAND, band);
    write_reg(REG_USE_HYSTERESIS, {junk[30:0], hyst});
    if ($urandom_range(0, 1) == 0)
      write_reg(REG_UNMAPPED + 3'($urandom_range(0, 1)), $urandom);
  endtask

  initial begin
    stim_row_t       row;
    bit              last_was_write;
    contact_result_t no_result;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    typed_next   = 1'b0;
    typed_result = '{default: '0};
    no_result    = '{default: '0};
    hold_pending = 1'b0;
    tx_idle      = 1'b1;
    rx_idle      = 1'b1;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // directed table; register writes only once the pipeline has emptied
    build_table();
    last_was_write = 1'b0;
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_write) begin
        if (!last_was_write) drain_and_settle();
        write_reg(row.reg_index, row.reg_value);
      end else begin
        send_item(row.item, row.typed, row.result);
      end
      last_was_write = row.is_write;
    end

    // random phases, each with fresh register settings and idling style
    for (int p = 0; p < PHASES; p++) begin
      drain_and_settle();
      random_config(p);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (p == PRESSURE_PHASE) begin
        // sender runs flat out while the receiver holds off
        tx_idle      = 1'b0;
        hold_pending = 1'b1;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(), 1'b0, no_result);
    end

    drain_and_settle();
    if (mismatches == 0 && contact_q.size() == 0) begin
      $display("PASS gap_spring_contact_state_top");
    end else begin
      $display("FAIL gap_spring_contact_state_top");
    end
    $finish;
  end

endmodule
